// ----- sv/pwmm_pkg.sv -----
// Shared types and constants of the PWM input duty and frequency meter.
`default_nettype none

package pwmm_pkg;

  localparam int unsigned CNT_W       = 16;
  localparam int unsigned DUTY_MUL_W  = 15;
  localparam int unsigned DIV_W       = CNT_W + DUTY_MUL_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_W);
  localparam int unsigned RATE_W      = 27;
  localparam int unsigned DUTY_W      = 15;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = RATE_W;

  localparam logic [DUTY_W-1:0] DUTY_FULL     = DUTY_W'(25600);
  localparam logic [RATE_W-1:0] TICK_RATE_RST = RATE_W'(1000000);
  localparam logic [CNT_W-1:0]  CNT_MAX       = {CNT_W{1'b1}};

  localparam logic [STATUS_W-1:0] STAT_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_READY   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ZERO_PERIOD = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_EDGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE  = 1'b1;

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_HIGH   = 4'b0010,
    PH_PERIOD = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    CS_IDLE = 3'b001,
    CS_DUTY = 3'b010,
    CS_FREQ = 3'b100
  } ctrl_state_e;

  typedef struct packed {
    logic tick;
    logic read_nr;
    logic read_zero;
    logic read_go;
    logic div_step;
    logic freq_load;
    logic finish;
    logic out_taken;
  } dp_cmd_t;

  typedef struct packed {
    logic phase_done;
    logic period_zero;
    logic out_valid;
    logic div_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- sv/pwmm_ctrl.sv -----
// Controller state machine: input handshake and divide sequencing.
`default_nettype none

module pwmm_ctrl
  import pwmm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_kind_i,
  output logic          in_stall_o,
  input  wire logic     out_stall_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        idle;
  logic        out_free;
  logic        acc;

  assign idle       = (state_q == CS_IDLE);
  assign out_free   = !stat_i.out_valid || !out_stall_i;
  assign in_stall_o = !idle || (in_kind_i && !out_free);
  assign acc        = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o.tick      = acc && !in_kind_i;
    cmd_o.read_nr   = acc && in_kind_i && !stat_i.phase_done;
    cmd_o.read_zero = acc && in_kind_i && stat_i.phase_done && stat_i.period_zero;
    cmd_o.read_go   = acc && in_kind_i && stat_i.phase_done && !stat_i.period_zero;
    cmd_o.div_step  = !idle;
    cmd_o.freq_load = (state_q == CS_DUTY) && stat_i.div_last;
    cmd_o.finish    = (state_q == CS_FREQ) && stat_i.div_last;
    cmd_o.out_taken = stat_i.out_valid && !out_stall_i;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (cmd_o.read_go) state_d = CS_DUTY;
      end
      CS_DUTY: begin
        if (stat_i.div_last) state_d = CS_FREQ;
      end
      CS_FREQ: begin
        if (stat_i.div_last) state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pwmm_dp.sv -----
// Datapath: edge capture, tick counter, shared divider and result register.
`default_nettype none

module pwmm_dp
  import pwmm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  pin_level_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire dp_cmd_t               cmd_i,
  output dp_stat_t                   stat_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [DUTY_W-1:0]          duty_q8_o,
  output logic [RATE_W-1:0]          frequency_hz_o,
  output logic [CNT_W-1:0]           high_ticks_o,
  output logic [CNT_W-1:0]           period_ticks_o
);

  logic              first_edge_q, first_edge_d;
  logic [RATE_W-1:0] tick_rate_q, tick_rate_d;
  phase_e            phase_q, phase_d;
  logic              sense_q, sense_d;
  logic              prev_q, prev_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  high_q, high_d;
  logic [CNT_W-1:0]  period_q, period_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;

  logic [CNT_W-1:0]     div_rem_q, div_rem_d;
  logic [DIV_W-1:0]     div_quo_q, div_quo_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic [DUTY_W-1:0]    duty_res_q, duty_res_d;

  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [DUTY_W-1:0]   res_duty_q, res_duty_d;
  logic [RATE_W-1:0]   res_freq_q, res_freq_d;
  logic [CNT_W-1:0]    res_high_q, res_high_d;
  logic [CNT_W-1:0]    res_period_q, res_period_d;

  logic             hit;
  logic [CNT_W:0]   rem_sh;
  logic [CNT_W:0]   rem_sub;
  logic             ge;
  logic [DIV_W-1:0] quo_nx;
  logic [DUTY_W-1:0] duty_cap;

  assign hit = sense_q ? (!prev_q && pin_level_i) : (prev_q && !pin_level_i);

  assign rem_sh   = {div_rem_q, div_quo_q[DIV_W-1]};
  assign ge       = (rem_sh >= {1'b0, period_q});
  assign rem_sub  = rem_sh - {1'b0, period_q};
  assign quo_nx   = {div_quo_q[DIV_W-2:0], ge};
  assign duty_cap = (quo_nx > DIV_W'(DUTY_FULL)) ? DUTY_FULL : quo_nx[DUTY_W-1:0];

  always_comb begin
    first_edge_d = first_edge_q;
    tick_rate_d  = tick_rate_q;
    phase_d      = phase_q;
    sense_d      = sense_q;
    prev_d       = prev_q;
    count_d      = count_q;
    high_d       = high_q;
    period_d     = period_q;
    ovf_d        = ovf_q;

    if (cmd_i.tick) begin
      prev_d = pin_level_i;
      if ((phase_q == PH_HIGH) || (phase_q == PH_PERIOD)) begin
        if (count_q == CNT_MAX) begin
          ovf_d = 1'b1;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      if (hit) begin
        case (phase_q)
          PH_START: begin
            count_d = '0;
            ovf_d   = 1'b0;
            sense_d = !sense_q;
            phase_d = PH_HIGH;
          end
          PH_HIGH: begin
            high_d  = count_d;
            sense_d = !sense_q;
            phase_d = PH_PERIOD;
          end
          PH_PERIOD: begin
            period_d = count_d;
            phase_d  = PH_DONE;
          end
          default: ;
        endcase
      end
    end

    if (cmd_i.read_zero || cmd_i.read_go) begin
      phase_d = PH_START;
      sense_d = first_edge_q;
      count_d = '0;
    end

    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FIRST_EDGE: begin
          first_edge_d = cfg_wdata_i[0];
          if (phase_q == PH_START) sense_d = cfg_wdata_i[0];
        end
        REG_TICK_RATE: tick_rate_d = cfg_wdata_i[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    div_rem_d  = div_rem_q;
    div_quo_d  = div_quo_q;
    div_cnt_d  = div_cnt_q;
    duty_res_d = duty_res_q;
    if (cmd_i.read_go) begin
      div_rem_d = '0;
      div_quo_d = DIV_W'(high_q) * DIV_W'(DUTY_FULL);
      div_cnt_d = '0;
    end else if (cmd_i.freq_load) begin
      duty_res_d = duty_cap;
      div_rem_d  = '0;
      div_quo_d  = DIV_W'(tick_rate_q);
      div_cnt_d  = '0;
    end else if (cmd_i.div_step) begin
      div_rem_d = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      div_quo_d = quo_nx;
      div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    res_status_d = res_status_q;
    res_duty_d   = res_duty_q;
    res_freq_d   = res_freq_q;
    res_high_d   = res_high_q;
    res_period_d = res_period_q;
    if (cmd_i.out_taken) out_valid_d = 1'b0;
    if (cmd_i.read_nr) begin
      out_valid_d  = 1'b1;
      res_status_d = STAT_NOT_READY;
      res_duty_d   = '0;
      res_freq_d   = '0;
      res_high_d   = '0;
      res_period_d = '0;
    end else if (cmd_i.read_zero) begin
      out_valid_d  = 1'b1;
      res_status_d = STAT_ZERO_PERIOD;
      res_duty_d   = '0;
      res_freq_d   = '0;
      res_high_d   = high_q;
      res_period_d = period_q;
    end else if (cmd_i.finish) begin
      out_valid_d  = 1'b1;
      res_status_d = ovf_q ? STAT_OVERFLOW : STAT_OK;
      res_duty_d   = duty_res_q;
      res_freq_d   = quo_nx[RATE_W-1:0];
      res_high_d   = high_q;
      res_period_d = period_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_edge_q <= 1'b0;
      tick_rate_q  <= TICK_RATE_RST;
      phase_q      <= PH_START;
      sense_q      <= 1'b0;
      prev_q       <= 1'b0;
      count_q      <= '0;
      high_q       <= '0;
      period_q     <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      div_cnt_q    <= '0;
    end else begin
      first_edge_q <= first_edge_d;
      tick_rate_q  <= tick_rate_d;
      phase_q      <= phase_d;
      sense_q      <= sense_d;
      prev_q       <= prev_d;
      count_q      <= count_d;
      high_q       <= high_d;
      period_q     <= period_d;
      ovf_q        <= ovf_d;
      out_valid_q  <= out_valid_d;
      div_cnt_q    <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_rem_q    <= div_rem_d;
    div_quo_q    <= div_quo_d;
    duty_res_q   <= duty_res_d;
    res_status_q <= res_status_d;
    res_duty_q   <= res_duty_d;
    res_freq_q   <= res_freq_d;
    res_high_q   <= res_high_d;
    res_period_q <= res_period_d;
  end

  always_comb begin
    stat_o.phase_done  = (phase_q == PH_DONE);
    stat_o.period_zero = (period_q == '0);
    stat_o.out_valid   = out_valid_q;
    stat_o.div_last    = (div_cnt_q == DIV_CNT_W'(DIV_W - 1));
  end

  assign status_o       = res_status_q;
  assign duty_q8_o      = res_duty_q;
  assign frequency_hz_o = res_freq_q;
  assign high_ticks_o   = res_high_q;
  assign period_ticks_o = res_period_q;

endmodule

`default_nettype wire

// ----- sv/pwm_input_duty_frequency_meter.sv -----
// Top level of the PWM input duty and frequency meter.
//
// Input channel (valid/stall): each transfer is a timer tick with a pin
// sample (kind 0) or a read request (kind 1). Ticks produce no result.
// A read produces exactly one result on the output channel.
// Ticks are taken one per cycle while no division runs. A read while no
// full cycle is measured, or with a zero period, returns its result in
// the cycle after the transfer. A read of a finished measurement runs
// two restoring divisions on one shared divider (duty, then frequency),
// one quotient bit per cycle over the 31-bit dividend; the input channel
// stalls until the result is written to the output register.
// The result sits in an output register; ticks keep flowing while it waits.
// A read is stalled while the output register is full and out_stall_i is
// high. Reset clears the measurement, sets the tick rate to 1000000 and
// the start edge to falling. Configuration writes are registered.
`default_nettype none

module pwm_input_duty_frequency_meter
  import pwmm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  in_kind_i,
  input  wire logic                  in_pin_level_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [STATUS_W-1:0]        out_status_o,
  output logic [DUTY_W-1:0]          out_duty_q8_o,
  output logic [RATE_W-1:0]          out_frequency_hz_o,
  output logic [CNT_W-1:0]           out_high_ticks_o,
  output logic [CNT_W-1:0]           out_period_ticks_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pwmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_kind_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pwmm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pin_level_i    (in_pin_level_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .status_o       (out_status_o),
    .duty_q8_o      (out_duty_q8_o),
    .frequency_hz_o (out_frequency_hz_o),
    .high_ticks_o   (out_high_ticks_o),
    .period_ticks_o (out_period_ticks_o)
  );

  assign out_valid_o = stat.out_valid;

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.read_go |=> in_stall_o)
    else $error("input not stalled while dividing");

  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_valid_o)
    else $error("finished result not presented");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.tick, cmd.read_nr, cmd.read_zero, cmd.read_go}))
    else $error("more than one transfer command");

  a_nr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_status_o == STAT_NOT_READY)) |->
      ((out_duty_q8_o == '0) && (out_frequency_hz_o == '0)))
    else $error("not-ready result carries data");

endmodule

`default_nettype wire
